### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, checked on clk, off during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### rtl/slcd_pkg.sv
// shared constants and types for the sync/length/checksum deframer
package slcd_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_LIMIT   = (MAX_FRAME > STORE_DEPTH) ? STORE_DEPTH : MAX_FRAME;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] SYNC_SUM    = SYNC_FIRST + SYNC_SECOND;

  typedef logic [1:0] status_t;
  localparam status_t ST_BODY  = 2'd0;
  localparam status_t ST_ERR   = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // frame completion from parser to emitter
  typedef struct packed {
    logic              fire;
    status_t           status;
    logic [ADDR_W-1:0] cnt_m1;
  } done_t;

endpackage

### rtl/slcd_if.sv
// request channel interfaces for received bytes and emitted results
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       frame_byte;
  logic             last;
  slcd_pkg::status_t status;

  modport source (output valid, output frame_byte, output last, output status, input ready);
  modport sink (input valid, input frame_byte, input last, input status, output ready);
endinterface

### rtl/slcd_ram.sv
// simple dual-port ram, one write and one registered read port
module slcd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/slcd_rx.sv
// frame parser: sync hunt, length, body store writes and checksum check
`include "assert_macros.svh"

module slcd_rx (
  input  logic                        clk,
  input  logic                        rst_n,
  slcd_in_if.sink                     in_chan,
  input  logic                        emit_rdy,
  output slcd_pkg::done_t             done,
  output logic                        wr_en,
  output logic [slcd_pkg::ADDR_W-1:0] wr_addr,
  output logic [7:0]                  wr_data
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] len_r, len_nxt;
  logic       acc;
  logic [7:0] b;
  logic       in_body;
  logic [7:0] body_off;

  assign in_chan.ready = emit_rdy;
  assign acc           = in_chan.valid && emit_rdy;
  assign b             = in_chan.rx_byte;
  assign in_body       = ({1'b0, pos_r} + 9'd1) < {1'b0, len_r};
  assign body_off      = pos_r - 8'd3;

  assign wr_addr = body_off[slcd_pkg::ADDR_W-1:0];
  assign wr_data = b;

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    wr_en       = 1'b0;
    done.fire   = 1'b0;
    done.status = slcd_pkg::ST_BODY;
    done.cnt_m1 = '0;
    if (acc) begin
      if (pos_r == 8'd0) begin
        if (b == slcd_pkg::SYNC_FIRST) begin
          pos_nxt = 8'd1;
        end
      end else if (pos_r == 8'd1) begin
        pos_nxt = (b == slcd_pkg::SYNC_SECOND) ? 8'd2 : 8'd0;
      end else if (pos_r == 8'd2) begin
        if (b > 8'(slcd_pkg::LEN_LIMIT)) begin
          pos_nxt = 8'd0;
        end else begin
          len_nxt = b;
          sum_nxt = slcd_pkg::SYNC_SUM + b;
          pos_nxt = 8'd3;
        end
      end else if (in_body) begin
        wr_en   = 1'b1;
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + 8'd1;
      end else begin
        pos_nxt   = 8'd0;
        done.fire = 1'b1;
        if (b != sum_r) begin
          done.status = slcd_pkg::ST_ERR;
        end else if (len_r >= 8'd5) begin
          done.status = slcd_pkg::ST_BODY;
          done.cnt_m1 = slcd_pkg::ADDR_W'(len_r - 8'd5);
        end else begin
          done.status = slcd_pkg::ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      len_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      len_r <= len_nxt;
    end
  end

  `CHK_NOW(a_pos_bound, pos_r >= 8'd3, pos_r < 8'(slcd_pkg::LEN_LIMIT))
  `CHK_NOW(a_wr_in_frame, wr_en, pos_r >= 8'd3 && len_r > 8'd4)

endmodule

### rtl/slcd_emit.sv
// result emitter: status results and body readout from the store
`include "assert_macros.svh"

module slcd_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  slcd_pkg::done_t             done,
  output logic                        emit_rdy,
  output logic                        rd_en,
  output logic [slcd_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  slcd_out_if.source                  out_chan
);

  typedef enum logic {E_IDLE, E_BODY} state_t;

  state_t                      state_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  slcd_pkg::status_t           out_status_r;
  logic                        rd_pend_r;
  logic                        rd_last_r;
  logic [slcd_pkg::ADDR_W-1:0] rd_idx_r;
  logic [slcd_pkg::ADDR_W-1:0] cnt_m1_r;
  logic                        out_free;
  logic                        stat_load;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_rdy  = (state_r == E_IDLE) && !rd_pend_r && out_free;
  assign rd_en     = (state_r == E_BODY) && !rd_pend_r && out_free;
  assign rd_addr   = rd_idx_r;
  assign stat_load = done.fire && (done.status != slcd_pkg::ST_BODY);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_byte = out_byte_r;
  assign out_chan.last       = out_last_r;
  assign out_chan.status     = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (done.fire) begin
        if (done.status == slcd_pkg::ST_BODY) begin
          state_r  <= E_BODY;
          rd_idx_r <= '0;
          cnt_m1_r <= done.cnt_m1;
        end else begin
          out_valid_r  <= 1'b1;
          out_byte_r   <= 8'd0;
          out_last_r   <= 1'b1;
          out_status_r <= done.status;
        end
      end
      if (rd_en) begin
        rd_pend_r <= 1'b1;
        rd_last_r <= (rd_idx_r == cnt_m1_r);
        rd_idx_r  <= rd_idx_r + slcd_pkg::ADDR_W'(1);
        if (rd_idx_r == cnt_m1_r) begin
          state_r <= E_IDLE;
        end
      end
      if (rd_pend_r) begin
        rd_pend_r    <= 1'b0;
        out_valid_r  <= 1'b1;
        out_byte_r   <= rd_data;
        out_last_r   <= rd_last_r;
        out_status_r <= slcd_pkg::ST_BODY;
      end else if (out_valid_r && out_chan.ready && !stat_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `CHK_NOW(a_pend_slot_free, rd_pend_r, !out_valid_r)
  `CHK_NOW(a_idx_bound, state_r == E_BODY, rd_idx_r <= cnt_m1_r)
  `CHK_NEXT(a_last_read_idle, rd_en && rd_idx_r == cnt_m1_r, state_r == E_IDLE && rd_pend_r)

endmodule

### rtl/sync_length_checksum_deframer_core.sv
// top level of the sync/length/checksum deframer
// Received bytes are taken one per cycle while the result register is free
// or being drained. A frame is 0xAA 0x55, a length byte L of at most 64, L-4
// body bytes and a sum8 checksum; body bytes go into a 64-entry store. When a
// good frame with a body completes, no input is taken while the body is read
// back and emitted: each body byte is read through the store's registered read
// port and loaded into the result register before the next read is issued.
// Checksum errors and empty frames give a single status result at once.
module sync_length_checksum_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  slcd_in_if.sink     in_chan,
  slcd_out_if.source  out_chan
);

  slcd_pkg::done_t             done;
  logic                        emit_rdy;
  logic                        wr_en;
  logic [slcd_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                  wr_data;
  logic                        rd_en;
  logic [slcd_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;

  slcd_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .emit_rdy (emit_rdy),
    .done     (done),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  slcd_ram #(
    .DEPTH (slcd_pkg::STORE_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  slcd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .done     (done),
    .emit_rdy (emit_rdy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_chan (out_chan)
  );

endmodule

### dv/sync_length_checksum_deframer_core_test.sv
// self-checking testbench for the sync/length/checksum deframer core
`timescale 1ns / 1ps

module sync_length_checksum_deframer_core_test;

  localparam int RANDOM_ITEMS = 196;
  localparam int QUIET_FROM   = 160;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_DIRECTED = 24;

  localparam logic [7:0] POS_HUNT  = 8'd0;
  localparam logic [7:0] POS_SYNC2 = 8'd1;
  localparam logic [7:0] POS_LEN   = 8'd2;
  localparam logic [7:0] POS_BODY  = 8'd3;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic              last;
    slcd_pkg::status_t status;
  } deframe_result_t;

  typedef struct packed {
    logic [7:0]      rx_byte;
    logic            typed;
    deframe_result_t res;
  } stim_row_t;

  typedef enum logic [2:0] {
    FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SYNC, FRAME_TOO_LONG, FRAME_NOISE
  } frame_kind_t;

  localparam deframe_result_t NO_RES    = '{8'h00, 1'b0, slcd_pkg::ST_BODY};
  localparam deframe_result_t EMPTY_RES = '{8'h00, 1'b1, slcd_pkg::ST_EMPTY};
  localparam deframe_result_t ERR_RES   = '{8'h00, 1'b1, slcd_pkg::ST_ERR};

  logic clk;
  logic rst_n;

  slcd_in_if  in_chan();
  slcd_out_if out_chan();

  sync_length_checksum_deframer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // expectation carried alongside a directed byte
  logic            in_typed;
  deframe_result_t in_typed_res;

  logic [7:0] frame_pos;
  logic [7:0] frame_sum;
  logic [7:0] frame_len;
  logic [7:0] rx_body [slcd_pkg::STORE_DEPTH];

  deframe_result_t pending_results[$];
  deframe_result_t discarded[$];

  bit gaps_on;
  bit hold_off_req;
  int errors;
  int results_checked;
  int long_holds;
  int cycle_count;
  int good_frames;
  int bad_frames;
  int broken_seqs;
  int longest_frame;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00,                 1'b0, NO_RES},
    '{8'hFF,                 1'b0, NO_RES},
    // repeated first sync byte goes back to hunting
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    // lengths above the limit
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    '{8'h41,                 1'b0, NO_RES},
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    '{8'hFF,                 1'b0, NO_RES},
    // zero length, good checksum
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    '{8'h00,                 1'b0, NO_RES},
    '{8'hFF,                 1'b1, EMPTY_RES},
    // length four, bad checksum
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    '{8'h04,                 1'b0, NO_RES},
    '{8'h00,                 1'b1, ERR_RES},
    // one body byte
    '{slcd_pkg::SYNC_FIRST,  1'b0, NO_RES},
    '{slcd_pkg::SYNC_SECOND, 1'b0, NO_RES},
    '{8'h05,                 1'b0, NO_RES},
    '{8'hFF,                 1'b0, NO_RES},
    '{8'h03,                 1'b0, NO_RES}
  };

  function automatic void deframe_byte(input logic [7:0] b, ref deframe_result_t res_q[$]);
    logic [5:0] idx;
    int         count;
    if (frame_pos == POS_HUNT) begin
      if (b == slcd_pkg::SYNC_FIRST) frame_pos = POS_SYNC2;
    end else if (frame_pos == POS_SYNC2) begin
      frame_pos = (b == slcd_pkg::SYNC_SECOND) ? POS_LEN : POS_HUNT;
    end else if (frame_pos == POS_LEN) begin
      if (int'(b) > slcd_pkg::LEN_LIMIT) begin
        frame_pos = POS_HUNT;
      end else begin
        frame_len = b;
        frame_sum = slcd_pkg::SYNC_SUM + b;
        frame_pos = POS_BODY;
      end
    end else if (int'(frame_pos) + 1 < int'(frame_len)) begin
      idx = 6'(frame_pos - POS_BODY);
      rx_body[idx] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 8'd1;
    end else begin
      frame_pos = POS_HUNT;
      if (b != frame_sum) begin
        res_q.push_back(ERR_RES);
      end else begin
        count = (frame_len >= 8'd4) ? int'(frame_len) - 4 : 0;
        if (count > slcd_pkg::STORE_DEPTH) count = slcd_pkg::STORE_DEPTH;
        if (count == 0) begin
          res_q.push_back(EMPTY_RES);
        end else begin
          for (int i = 0; i < count; i++) begin
            res_q.push_back('{rx_body[i], (i + 1 == count), slcd_pkg::ST_BODY});
          end
        end
      end
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("sync_length_checksum_deframer_core_test: errors");
    $finish;
  end

  always @(posedge clk) begin : scoreboard
    deframe_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: frame_byte %h last %b status %0d",
               out_chan.frame_byte, out_chan.last, out_chan.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %h, got %h", want.frame_byte, out_chan.frame_byte);
          errors++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_chan.last);
          errors++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_chan.status);
          errors++;
        end
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      if (in_typed) begin
        discarded.delete();
        deframe_byte(in_chan.rx_byte, discarded);
        pending_results.push_back(in_typed_res);
      end else begin
        deframe_byte(in_chan.rx_byte, pending_results);
      end
    end
  end

  initial begin : receiver
    out_chan.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
        long_holds++;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [7:0] b, input logic typed, input deframe_result_t res);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    in_typed        <= typed;
    in_typed_res    <= res;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len, output int counted);
    logic [7:0] seq[$];
    logic [7:0] sum;
    logic [7:0] r;
    int         nbody;
    counted = 0;
    case (kind)
      FRAME_GOOD, FRAME_BAD_SUM: begin
        seq.push_back(slcd_pkg::SYNC_FIRST);
        seq.push_back(slcd_pkg::SYNC_SECOND);
        seq.push_back(8'(len));
        sum = slcd_pkg::SYNC_SUM + 8'(len);
        nbody = (len >= 5) ? len - 4 : 0;
        for (int i = 0; i < nbody; i++) begin
          r = 8'($urandom_range(0, 255));
          seq.push_back(r);
          sum = sum + r;
        end
        if (kind == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        seq.push_back(sum);
      end
      FRAME_BAD_SYNC: begin
        seq.push_back(slcd_pkg::SYNC_FIRST);
        r = 8'($urandom_range(0, 255));
        if (r == slcd_pkg::SYNC_SECOND) r = slcd_pkg::SYNC_FIRST;
        seq.push_back(r);
      end
      FRAME_TOO_LONG: begin
        seq.push_back(slcd_pkg::SYNC_FIRST);
        seq.push_back(slcd_pkg::SYNC_SECOND);
        seq.push_back(8'($urandom_range(slcd_pkg::LEN_LIMIT + 1, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          r = 8'($urandom_range(0, 255));
          if (r == slcd_pkg::SYNC_FIRST) r = 8'h00;
          seq.push_back(r);
        end
      end
    endcase
    foreach (seq[i]) offer(seq[i], 1'b0, NO_RES);
    counted = seq.size();
    if (kind == FRAME_GOOD || kind == FRAME_BAD_SUM) begin
      if (counted > longest_frame) longest_frame = counted;
      if (kind == FRAME_GOOD) good_frames++;
      else bad_frames++;
    end else begin
      broken_seqs++;
    end
  endtask

  initial begin : stimulus
    int          random_items;
    int          frame_idx;
    int          pick;
    int          len;
    int          counted;
    frame_kind_t kind;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.rx_byte <= 8'h00;
    in_typed        <= 1'b0;
    in_typed_res    <= NO_RES;
    frame_pos = POS_HUNT;
    frame_sum = 8'h00;
    frame_len = 8'h00;
    gaps_on = 1'b1;
    random_items = 0;
    frame_idx = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].res);
    end

    // drain everything before the random part
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);

    while (random_items < RANDOM_ITEMS) begin
      gaps_on = (random_items < QUIET_FROM) && (frame_idx % 6 != 5);
      pick = $urandom_range(0, 99);
      if (pick < 65) kind = FRAME_GOOD;
      else if (pick < 80) kind = FRAME_BAD_SUM;
      else if (pick < 88) kind = FRAME_BAD_SYNC;
      else if (pick < 94) kind = FRAME_TOO_LONG;
      else kind = FRAME_NOISE;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 4);
      else len = $urandom_range(5, 16);
      if (frame_idx == 2 || frame_idx == 12) begin
        kind = FRAME_GOOD;
        len = slcd_pkg::LEN_LIMIT;
      end
      // long receiver stall: body emission backs up into the input
      if (frame_idx == 4) begin
        hold_off_req = 1'b1;
        kind = FRAME_GOOD;
        len = 12;
      end
      send_frame(kind, len, counted);
      random_items += counted;
      frame_idx++;
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random bytes, %0d results checked",
             NUM_DIRECTED, random_items, results_checked);
    $display("%0d good and %0d bad-checksum frames, %0d malformed runs,",
             good_frames, bad_frames, broken_seqs,
             " longest %0d bytes, %0d long stalls", longest_frame, long_holds);
    if (errors == 0) begin
      $display("sync_length_checksum_deframer_core_test: clean");
    end else begin
      $display("sync_length_checksum_deframer_core_test: errors");
    end
    $finish;
  end

endmodule
